FILE: design/gbhe_pkg.sv
// Shared constants, types and the exponent table of the Gaussian bias history evaluator.
package gbhe_pkg;

   localparam int HISTORY_DEPTH  = 4096;
   localparam int HIST_AW        = $clog2(HISTORY_DEPTH);
   localparam int COUNT_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int EXP_TABLE_BITS = 10;
   localparam int EXP_TABLE_SIZE = 1 << EXP_TABLE_BITS;

   localparam logic [63:0] CAP       = 64'd1 << 61;
   localparam logic [31:0] LN2_Q30   = 32'd744261118;
   localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

   localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

   // Item kinds.
   localparam logic [1:0] KIND_APPEND    = 2'd0;
   localparam logic [1:0] KIND_FORCE     = 2'd1;
   localparam logic [1:0] KIND_POTENTIAL = 2'd2;
   localparam logic [1:0] KIND_AVERAGED  = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_BIAS_HEIGHT    = 3'd0;
   localparam logic [2:0] REG_KERNEL_WIDTH   = 3'd1;
   localparam logic [2:0] REG_BARRIER        = 3'd2;
   localparam logic [2:0] REG_WALL_STIFFNESS = 3'd3;
   localparam logic [2:0] REG_PLACE_WEIGHT   = 3'd4;
   localparam logic [2:0] REG_CUTOFF_WIDTHS  = 3'd5;

   typedef struct packed {
      logic        done;
      logic        sat;
      logic [61:0] value;
   } mul_rsp_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef logic [30:0] exp_tab_type [EXP_TABLE_SIZE];

   // Floor of num / den by shift and subtract; only evaluated while the table is built.
   function automatic longint unsigned div_floor(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // 2^(i/2^EXP_TABLE_BITS) in Q1.30 from a twelve term series of exp(i*ln2/size).
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type     tab;
      longint unsigned x;
      longint unsigned sum;
      longint unsigned term;
      for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
         x    = (longint'(i) * longint'(LN2_Q30)) >> EXP_TABLE_BITS;
         sum  = 64'd1 << 30;
         term = 64'd1 << 30;
         for (int n = 1; n <= 12; n++) begin
            term = div_floor((term * x) >> 30, 64'(n));
            sum  = sum + term;
         end
         tab[i] = sum[30:0];
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

FILE: design/gbhe_mul.sv
// Shared 64x64 multiplier built from four 32x32 partial products, with scale and clamp.
module gbhe_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [63:0]              a,
   input  logic [63:0]              b,
   input  logic signed [9:0]        shl,
   output gbhe_pkg::mul_rsp_type    rsp
);

   logic               busy_ff, busy_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [63:0]        a_ff, a_in, b_ff, b_in;
   logic signed [9:0]  shl_ff, shl_in;
   logic [127:0]       acc_ff, acc_in;
   logic               done_ff, done_in;
   logic               sat_ff, sat_in;
   logic [61:0]        val_ff, val_in;

   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [1:0]   off;
   logic [127:0] pp_sh;
   logic [9:0]   nsh;
   logic [127:0] r_sh;
   logic [63:0]  cap_sh;
   logic [61:0]  fit_val;
   logic         fit_sat;

   always_comb begin
      a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp     = a_half * b_half;
      off    = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
      pp_sh  = {64'd0, pp} << {off, 5'd0};
   end

   // Scale the full product by 2^shl, flooring, and clamp the magnitude to 2^61.
   always_comb begin
      nsh     = 10'(-shl_ff);
      r_sh    = acc_ff >> nsh[6:0];
      cap_sh  = gbhe_pkg::CAP >> shl_ff[5:0];
      fit_val = '0;
      fit_sat = 1'b0;
      if (acc_ff != '0) begin
         if (!shl_ff[9]) begin
            if (shl_ff >= 10'sd61 || acc_ff[127:64] != '0 || acc_ff[63:0] > cap_sh) begin
               fit_val = gbhe_pkg::CAP[61:0];
               fit_sat = 1'b1;
            end else begin
               fit_val = 62'(acc_ff[63:0] << shl_ff[5:0]);
            end
         end else if (nsh < 10'd128) begin
            if (r_sh > {64'd0, gbhe_pkg::CAP}) begin
               fit_val = gbhe_pkg::CAP[61:0];
               fit_sat = 1'b1;
            end else begin
               fit_val = r_sh[61:0];
            end
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      shl_in  = shl_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      val_in  = val_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = b;
         shl_in  = shl;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            sat_in  = fit_sat;
            val_in  = fit_val;
         end else begin
            acc_in = acc_ff + pp_sh;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      shl_ff <= shl_in;
      acc_ff <= acc_in;
      sat_ff <= sat_in;
      val_ff <= val_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.sat   = sat_ff;
   assign rsp.value = val_ff;

endmodule

FILE: design/gbhe_div.sv
// Shared restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module gbhe_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [63:0]              num,
   input  logic [31:0]              den,
   output gbhe_pkg::div_rsp_type    rsp
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        done_ff, done_in;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      trial = {rem_ff, quo_ff[63]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], ge};
         rem_in = ge ? diff[31:0] : trial[31:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: design/gaussian_bias_history_evaluator_core.sv
// Top level of the Gaussian bias history evaluator: history memories and query sequencer.
//
// An append beat writes the next history slot (ignored once all 4096 slots are full). A query
// with a nonzero bias height walks every stored entry in order (a force query at or beyond
// the barrier walks none) under a small sequencer that shares one 64x64 multiplier and one
// divider. An entry beyond the cutoff is passed over after its compare; an entry inside it
// costs one divide for a potential query and two for a force query, plus the multiplier
// passes. The block takes no new beat while a query runs, and a finished result waits in the
// output register.
module gaussian_bias_history_evaluator_core (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // position [31:0], entry_weight [63:32]
   input  logic [1:0]  req_tuser,    // kind [1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // value [47:0]
   output logic        rsp_tuser,    // saturated [0]
   // Configuration port.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_Q2   = 5'd1;
   localparam logic [4:0] ST_AXSQ = 5'd2;
   localparam logic [4:0] ST_CM   = 5'd3;
   localparam logic [4:0] ST_HSQ  = 5'd4;
   localparam logic [4:0] ST_HARM = 5'd5;
   localparam logic [4:0] ST_READ = 5'd6;
   localparam logic [4:0] ST_CMP  = 5'd7;
   localparam logic [4:0] ST_DIVF = 5'd8;
   localparam logic [4:0] ST_G    = 5'd9;
   localparam logic [4:0] ST_DIVQ = 5'd10;
   localparam logic [4:0] ST_M    = 5'd11;
   localparam logic [4:0] ST_EXP  = 5'd12;
   localparam logic [4:0] ST_TAB  = 5'd13;
   localparam logic [4:0] ST_TERM = 5'd14;
   localparam logic [4:0] ST_KERN = 5'd15;
   localparam logic [4:0] ST_AVG  = 5'd16;
   localparam logic [4:0] ST_DONE = 5'd17;

   localparam int TB = gbhe_pkg::EXP_TABLE_BITS;
   localparam int CW = gbhe_pkg::COUNT_W;

   // Configuration registers.
   logic [23:0]        bias_ff;
   logic [30:0]        width_ff;
   logic [30:0]        barr_ff;
   logic [30:0]        stiff_ff;
   logic signed [31:0] pw_ff;
   logic [7:0]         cutoff_ff;

   // History memories.
   logic [31:0] hist_pos_mem [gbhe_pkg::HISTORY_DEPTH];
   logic [31:0] hist_wt_mem  [gbhe_pkg::HISTORY_DEPTH];
   logic [31:0] pos_rd_ff;
   logic [31:0] wt_rd_ff;
   logic        hist_we;

   // Sequencer state.
   logic [4:0]         state_ff, state_in;
   logic               pend_ff, pend_in;
   logic [1:0]         kind_ff, kind_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] xc_ff, xc_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [39:0] q2_ff, q2_in;
   logic [61:0]        tmp_ff, tmp_in;
   logic [44:0]        cm_ff, cm_in;
   logic [61:0]        harm_ff, harm_in;
   logic [32:0]        ad_ff, ad_in;
   logic               dneg_ff, dneg_in;
   logic [31:0]        f_ff, f_in;
   logic [39:0]        g_ff, g_in;
   logic signed [57:0] inner_ff, inner_in;
   logic [61:0]        m_ff, m_in;
   logic signed [34:0] t_ff, t_in;
   logic signed [9:0]  k_ff, k_in;
   logic [30:0]        mant_ff, mant_in;
   logic signed [62:0] acc_ff, acc_in;
   logic [61:0]        sum_ff, sum_in;
   logic [61:0]        kern_ff, kern_in;
   logic               sat_ff, sat_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_value_ff, rsp_value_in;
   logic        rsp_sat_ff, rsp_sat_in;

   // Shared units.
   logic                   mul_start;
   logic [63:0]            mul_a, mul_b;
   logic signed [9:0]      mul_shl;
   gbhe_pkg::mul_rsp_type  mul_rsp;
   logic                   div_start;
   logic [63:0]            div_num;
   logic [31:0]            div_den;
   gbhe_pkg::div_rsp_type  div_rsp;

   // Derived values.
   logic [30:0]        width_eff;
   logic [38:0]        lim;
   logic [31:0]        ac;
   logic [31:0]        ax;
   logic [31:0]        ax_x;
   logic [32:0]        dmag;
   logic signed [32:0] barr_s;
   logic signed [32:0] rx;
   logic               below, above;
   logic               is_force, is_ave;
   logic signed [32:0] diff;
   logic [32:0]        ad;
   logic [CW-1:0]      half_start, half_size, aw;
   logic [55:0]        q1;
   logic signed [57:0] q1_s;
   logic [56:0]        inner_mag;
   logic signed [47:0] e_raw;
   logic signed [32:0] ec;
   logic signed [64:0] tprod;
   logic [61:0]        acc_mag;
   logic signed [63:0] acc_sum;
   logic [62:0]        sum_sum;
   logic signed [63:0] kern_s, harm_s, fin_v;
   logic               x_gt_barr;
   logic [47:0]        out_val;
   logic               out_sat;
   logic               rsp_load;

   gbhe_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .shl   (mul_shl),
      .rsp   (mul_rsp)
   );

   gbhe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .rsp   (div_rsp)
   );

   always_comb begin
      width_eff  = (width_ff == '0) ? 31'd1 : width_ff;
      lim        = 39'(cutoff_ff) * 39'(width_eff);
      ac         = pw_ff[31] ? 32'(-pw_ff) : 32'(pw_ff);
      ax         = xc_ff[31] ? 32'(-xc_ff) : 32'(xc_ff);
      ax_x       = x_ff[31] ? 32'(-x_ff) : 32'(x_ff);
      dmag       = {1'b0, ax_x} - {2'b0, barr_ff};
      barr_s     = $signed({2'b0, barr_ff});
      rx         = $signed({req_tdata[31], req_tdata[31:0]});
      below      = rx < -barr_s;
      above      = rx > barr_s;
      is_force   = (kind_ff == gbhe_pkg::KIND_FORCE);
      is_ave     = (kind_ff == gbhe_pkg::KIND_AVERAGED);
      diff       = $signed({xc_ff[31], xc_ff}) - $signed({pos_rd_ff[31], pos_rd_ff});
      ad         = diff[32] ? 33'(-diff) : 33'(diff);
      half_start = count_ff >> 1;
      half_size  = count_ff - half_start;
      if (!is_ave) begin
         aw = CW'(1);
      end else if (idx_ff > half_start) begin
         aw = count_ff - idx_ff;
      end else begin
         aw = half_size;
      end
      q1         = div_rsp.quotient[55:0];
      q1_s       = dneg_ff ? -$signed({2'b0, q1}) : $signed({2'b0, q1});
      inner_mag  = inner_ff[57] ? 57'(-inner_ff) : 57'(inner_ff);
      e_raw      = (pw_ff[31] ? -$signed({3'b0, cm_ff}) : $signed({3'b0, cm_ff}))
                   - $signed({8'b0, g_ff});
      if (e_raw > 48'sd2147483648) begin
         ec = 33'sd2147483648;
      end else if (e_raw < -48'sd2147483648) begin
         ec = -33'sd2147483648;
      end else begin
         ec = e_raw[32:0];
      end
      tprod      = 65'(ec) * $signed({33'd0, gbhe_pkg::LOG2E_Q30});
      acc_mag    = acc_ff[62] ? 62'(-acc_ff) : 62'(acc_ff);
      acc_sum    = 64'(acc_ff) + (inner_ff[57] ? -$signed({2'b0, mul_rsp.value})
                                               : $signed({2'b0, mul_rsp.value}));
      sum_sum    = {1'b0, sum_ff} + {1'b0, mul_rsp.value};
   end

   // Final result with full-scale clipping.
   always_comb begin
      x_gt_barr = $signed({x_ff[31], x_ff}) > barr_s;
      kern_s    = $signed({2'b0, kern_ff});
      harm_s    = $signed({2'b0, harm_ff});
      if (is_force && acc_ff[62]) begin
         kern_s = -kern_s;
      end
      if (is_force && x_gt_barr) begin
         harm_s = -harm_s;
      end
      fin_v   = kern_s + harm_s;
      out_sat = 1'b0;
      if (sat_ff) begin
         out_sat = 1'b1;
         out_val = fin_v[63] ? gbhe_pkg::OUT_MIN[47:0] : gbhe_pkg::OUT_MAX[47:0];
      end else if (fin_v > gbhe_pkg::OUT_MAX) begin
         out_sat = 1'b1;
         out_val = gbhe_pkg::OUT_MAX[47:0];
      end else if (fin_v < gbhe_pkg::OUT_MIN) begin
         out_sat = 1'b1;
         out_val = gbhe_pkg::OUT_MIN[47:0];
      end else begin
         out_val = fin_v[47:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      kind_in   = kind_ff;
      x_in      = x_ff;
      xc_in     = xc_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      q2_in     = q2_ff;
      tmp_in    = tmp_ff;
      cm_in     = cm_ff;
      harm_in   = harm_ff;
      ad_in     = ad_ff;
      dneg_in   = dneg_ff;
      f_in      = f_ff;
      g_in      = g_ff;
      inner_in  = inner_ff;
      m_in      = m_ff;
      t_in      = t_ff;
      k_in      = k_ff;
      mant_in   = mant_ff;
      acc_in    = acc_ff;
      sum_in    = sum_ff;
      kern_in   = kern_ff;
      sat_in    = sat_ff;
      hist_we   = 1'b0;
      rsp_load  = 1'b0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mul_shl   = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               x_in    = $signed(req_tdata[31:0]);
               xc_in   = $signed(req_tdata[31:0]);
               idx_in  = '0;
               acc_in  = '0;
               sum_in  = '0;
               kern_in = '0;
               harm_in = '0;
               sat_in  = 1'b0;
               pend_in = 1'b0;
               if (req_tuser == gbhe_pkg::KIND_APPEND) begin
                  if (count_ff < CW'(gbhe_pkg::HISTORY_DEPTH)) begin
                     hist_we  = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else if (bias_ff == '0) begin
                  state_in = ST_DONE;
               end else if (req_tuser == gbhe_pkg::KIND_FORCE) begin
                  if (below || above) begin
                     state_in = ST_HARM;
                  end else if (rx == barr_s || rx == -barr_s) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_Q2;
                  end
               end else begin
                  if (below) begin
                     xc_in    = -$signed({1'b0, barr_ff});
                     state_in = ST_HSQ;
                  end else if (above) begin
                     xc_in    = $signed({1'b0, barr_ff});
                     state_in = ST_HSQ;
                  end else begin
                     state_in = ST_AXSQ;
                  end
               end
            end
         end
         ST_Q2: begin
            mul_a     = 64'(ac);
            mul_b     = 64'(ax);
            mul_shl   = -10'sd24;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               sat_in   = sat_ff | mul_rsp.sat;
               q2_in    = (pw_ff[31] != xc_ff[31]) ? -$signed({1'b0, mul_rsp.value[38:0]})
                                                   : $signed({1'b0, mul_rsp.value[38:0]});
               state_in = ST_AXSQ;
            end
         end
         ST_AXSQ: begin
            mul_a     = 64'(ax);
            mul_b     = 64'(ax);
            mul_shl   = -10'sd24;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               sat_in   = sat_ff | mul_rsp.sat;
               tmp_in   = mul_rsp.value;
               state_in = ST_CM;
            end
         end
         ST_CM: begin
            mul_a     = 64'(tmp_ff);
            mul_b     = 64'(ac);
            mul_shl   = -10'sd25;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               sat_in   = sat_ff | mul_rsp.sat;
               cm_in    = mul_rsp.value[44:0];
               state_in = ST_READ;
            end
         end
         ST_HSQ: begin
            mul_a     = 64'(dmag);
            mul_b     = 64'(dmag);
            mul_shl   = -10'sd24;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               sat_in   = sat_ff | mul_rsp.sat;
               tmp_in   = mul_rsp.value;
               state_in = ST_HARM;
            end
         end
         ST_HARM: begin
            mul_a     = is_force ? 64'(dmag) : 64'(tmp_ff);
            mul_b     = 64'(stiff_ff);
            mul_shl   = is_force ? -10'sd24 : -10'sd25;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               sat_in   = sat_ff | mul_rsp.sat;
               harm_in  = mul_rsp.value;
               state_in = is_force ? ST_DONE : ST_AXSQ;
            end
         end
         ST_READ: begin
            // The memories are read at idx_ff every cycle; data is ready in the next state.
            state_in = (idx_ff == count_ff) ? ST_KERN : ST_CMP;
         end
         ST_CMP: begin
            if ({6'd0, ad} >= lim) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_READ;
            end else begin
               ad_in    = ad;
               dneg_in  = diff[32];
               state_in = ST_DIVF;
            end
         end
         ST_DIVF: begin
            div_num   = {7'd0, ad_ff, 24'd0};
            div_den   = 32'(width_eff);
            div_start = !pend_ff;
            pend_in   = 1'b1;
            if (div_rsp.done) begin
               pend_in  = 1'b0;
               f_in     = div_rsp.quotient[31:0];
               state_in = ST_G;
            end
         end
         ST_G: begin
            mul_a     = 64'(f_ff);
            mul_b     = 64'(f_ff);
            mul_shl   = -10'sd25;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               g_in     = mul_rsp.value[39:0];
               state_in = is_force ? ST_DIVQ : ST_EXP;
            end
         end
         ST_DIVQ: begin
            div_num   = {8'd0, f_ff, 24'd0};
            div_den   = 32'(width_eff);
            div_start = !pend_ff;
            pend_in   = 1'b1;
            if (div_rsp.done) begin
               pend_in  = 1'b0;
               inner_in = q1_s - 58'(q2_ff);
               state_in = ST_M;
            end
         end
         ST_M: begin
            mul_a     = 64'(inner_mag);
            mul_b     = 64'(wt_rd_ff);
            mul_shl   = -10'sd24;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               sat_in   = sat_ff | mul_rsp.sat;
               m_in     = mul_rsp.value;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            // exp(e) = 2^(e*log2 e); the arithmetic shift floors toward minus infinity.
            t_in     = tprod[64:30];
            state_in = ST_TAB;
         end
         ST_TAB: begin
            k_in     = t_ff[33:24];
            mant_in  = gbhe_pkg::EXP_TAB[t_ff[23 -: TB]];
            state_in = ST_TERM;
         end
         ST_TERM: begin
            mul_a     = is_force ? 64'(m_ff) : 64'({aw, 24'd0});
            mul_b     = 64'(mant_ff);
            mul_shl   = k_ff - 10'sd30;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in = 1'b0;
               sat_in  = sat_ff | mul_rsp.sat;
               if (is_force) begin
                  if (acc_sum > $signed(gbhe_pkg::CAP)) begin
                     acc_in = 63'(gbhe_pkg::CAP);
                     sat_in = 1'b1;
                  end else if (acc_sum < -$signed(gbhe_pkg::CAP)) begin
                     acc_in = -63'(gbhe_pkg::CAP);
                     sat_in = 1'b1;
                  end else begin
                     acc_in = acc_sum[62:0];
                  end
               end else begin
                  if (sum_sum > 63'(gbhe_pkg::CAP)) begin
                     sum_in = gbhe_pkg::CAP[61:0];
                     sat_in = 1'b1;
                  end else begin
                     sum_in = sum_sum[61:0];
                  end
               end
               idx_in   = idx_ff + CW'(1);
               state_in = ST_READ;
            end
         end
         ST_KERN: begin
            mul_a     = is_force ? 64'(acc_mag) : 64'(sum_ff);
            mul_b     = 64'(bias_ff);
            mul_shl   = -10'sd24;
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               sat_in   = sat_ff | mul_rsp.sat;
               kern_in  = mul_rsp.value;
               state_in = is_ave ? ST_AVG : ST_DONE;
            end
         end
         ST_AVG: begin
            if (half_size == '0) begin
               kern_in  = '0;
               state_in = ST_DONE;
            end else begin
               div_num   = 64'(kern_ff);
               div_den   = 32'(half_size);
               div_start = !pend_ff;
               pend_in   = 1'b1;
               if (div_rsp.done) begin
                  pend_in  = 1'b0;
                  kern_in  = div_rsp.quotient[61:0];
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = out_val;
         rsp_sat_in   = out_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_pos_mem[count_ff[gbhe_pkg::HIST_AW-1:0]] <= req_tdata[31:0];
         hist_wt_mem[count_ff[gbhe_pkg::HIST_AW-1:0]]  <= req_tdata[63:32];
      end
      pos_rd_ff <= hist_pos_mem[idx_ff[gbhe_pkg::HIST_AW-1:0]];
      wt_rd_ff  <= hist_wt_mem[idx_ff[gbhe_pkg::HIST_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff   <= 24'd167772;
         width_ff  <= 31'd4194304;
         barr_ff   <= 31'd36909875;
         stiff_ff  <= 31'd167772160;
         pw_ff     <= 32'sd16777216;
         cutoff_ff <= 8'd50;
      end else if (csr_we) begin
         unique case (csr_index)
            gbhe_pkg::REG_BIAS_HEIGHT:    bias_ff   <= csr_wdata[23:0];
            gbhe_pkg::REG_KERNEL_WIDTH:   width_ff  <= csr_wdata[30:0];
            gbhe_pkg::REG_BARRIER:        barr_ff   <= csr_wdata[30:0];
            gbhe_pkg::REG_WALL_STIFFNESS: stiff_ff  <= csr_wdata[30:0];
            gbhe_pkg::REG_PLACE_WEIGHT:   pw_ff     <= $signed(csr_wdata);
            gbhe_pkg::REG_CUTOFF_WIDTHS:  cutoff_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      x_ff         <= x_in;
      xc_ff        <= xc_in;
      idx_ff       <= idx_in;
      q2_ff        <= q2_in;
      tmp_ff       <= tmp_in;
      cm_ff        <= cm_in;
      harm_ff      <= harm_in;
      ad_ff        <= ad_in;
      dneg_ff      <= dneg_in;
      f_ff         <= f_in;
      g_ff         <= g_in;
      inner_ff     <= inner_in;
      m_ff         <= m_in;
      t_ff         <= t_in;
      k_ff         <= k_in;
      mant_ff      <= mant_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
      kern_ff      <= kern_in;
      sat_ff       <= sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule
